### hdl/phdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phdr_pkg
// Shared types and constants for the packet header parser.
// ----------------------------------------------------------------------------
package phdr_pkg;

  // Frame length limit: bytes past this count are not parsed
  localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;
  // IPv4 header length unit in bytes
  localparam int unsigned IHL_UNIT = 4;

  // Parse phases
  localparam logic [2:0] PH_ETH  = 3'd0;
  localparam logic [2:0] PH_IPV4 = 3'd1;
  localparam logic [2:0] PH_IPV6 = 3'd2;
  localparam logic [2:0] PH_TCP  = 3'd3;
  localparam logic [2:0] PH_UDP  = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  // Record layer codes
  localparam logic [2:0] LYR_ETH   = 3'd0;
  localparam logic [2:0] LYR_IPV4  = 3'd1;
  localparam logic [2:0] LYR_IPV6  = 3'd2;
  localparam logic [2:0] LYR_TCP   = 3'd3;
  localparam logic [2:0] LYR_UDP   = 3'd4;
  localparam logic [2:0] LYR_SHORT = 3'd5;
  localparam logic [2:0] LYR_END   = 3'd6;

  // Record status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNC     = 2'd1;
  localparam logic [1:0] ST_TRUNC_IHL = 2'd2;
  localparam logic [1:0] ST_BAD_IHL   = 2'd3;

  // Protocol numbers and EtherTypes followed by the parser
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // Record queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [2:0]  layer;
    logic [1:0]  status;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [15:0] type_or_proto;
    logic        last_of_frame;
  } rec_t;

  // Records produced by one accepted byte, packed first-come first
  typedef struct packed {
    logic first_vld;
    logic second_vld;
    rec_t first;
    rec_t second;
  } push_t;

endpackage : phdr_pkg
`default_nettype wire

### hdl/phdr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phdr_parser
// Per-byte header walker: phase, offset and field capture, record emission.
// ----------------------------------------------------------------------------
module phdr_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   byte_i,
  input  wire logic         eof_i,
  output phdr_pkg::push_t   push_o
);
  import phdr_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [6:0]  off_q, off_d;
  logic [5:0]  ihl_q, ihl_d;
  logic [15:0] cnt_q, cnt_d;
  logic [63:0] sh_q, sh_d, sl_q, sl_d, dh_q, dh_d, dl_q, dl_d;
  logic [15:0] type_q, type_d;

  logic [6:0]  off_inc;
  logic        hdr_vld;
  rec_t        hdr_rec;
  logic        eof_vld;
  rec_t        eof_rec;

  function automatic logic [2:0] ip_next(input logic [15:0] proto);
    logic [2:0] ph;
    ph = PH_SKIP;
    if (proto == {8'd0, PROTO_TCP}) ph = PH_TCP;
    else if (proto == {8'd0, PROTO_UDP}) ph = PH_UDP;
    return ph;
  endfunction

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    ihl_d   = ihl_q;
    cnt_d   = cnt_q;
    sh_d    = sh_q;
    sl_d    = sl_q;
    dh_d    = dh_q;
    dl_d    = dl_q;
    type_d  = type_q;
    off_inc = off_q + 7'd1;
    hdr_vld = 1'b0;
    hdr_rec = '0;
    eof_vld = 1'b0;
    eof_rec = '0;

    if (cnt_q < MAX_FRAME_BYTES) begin
      cnt_d = cnt_q + 16'd1;
      case (phase_q)
        PH_ETH: begin
          if (off_q < 7'd6) dl_d = {dl_q[55:0], byte_i};
          else if (off_q < 7'd12) sl_d = {sl_q[55:0], byte_i};
          else type_d = {type_q[7:0], byte_i};
          off_d = off_inc;
          if (off_inc == 7'd14) begin
            hdr_vld               = 1'b1;
            hdr_rec.layer         = LYR_ETH;
            hdr_rec.status        = ST_OK;
            hdr_rec.src_low       = sl_d;
            hdr_rec.dst_low       = dl_d;
            hdr_rec.type_or_proto = type_d;
            phase_d = (type_d == ETYPE_IPV4) ? PH_IPV4 :
                      (type_d == ETYPE_IPV6) ? PH_IPV6 : PH_SKIP;
          end
        end
        PH_IPV4: begin
          if (off_q == 7'd0) ihl_d = 6'(32'(byte_i[3:0]) * IHL_UNIT);
          else if (off_q == 7'd9) type_d = {8'd0, byte_i};
          else if (off_q >= 7'd12 && off_q < 7'd16) sl_d = {sl_q[55:0], byte_i};
          else if (off_q >= 7'd16 && off_q < 7'd20) dl_d = {dl_q[55:0], byte_i};
          off_d = off_inc;
          if (off_inc == 7'd20 && ihl_d < 6'd20) begin
            hdr_vld               = 1'b1;
            hdr_rec.layer         = LYR_IPV4;
            hdr_rec.status        = ST_BAD_IHL;
            hdr_rec.src_low       = sl_d;
            hdr_rec.dst_low       = dl_d;
            hdr_rec.type_or_proto = type_d;
            phase_d = PH_SKIP;
          end else if (off_inc >= 7'd20 && off_inc >= {1'b0, ihl_d}) begin
            hdr_vld               = 1'b1;
            hdr_rec.layer         = LYR_IPV4;
            hdr_rec.status        = ST_OK;
            hdr_rec.src_low       = sl_d;
            hdr_rec.dst_low       = dl_d;
            hdr_rec.type_or_proto = type_d;
            phase_d = ip_next(type_d);
          end
        end
        PH_IPV6: begin
          if (off_q == 7'd6) type_d = {8'd0, byte_i};
          else if (off_q >= 7'd8 && off_q < 7'd16) sh_d = {sh_q[55:0], byte_i};
          else if (off_q >= 7'd16 && off_q < 7'd24) sl_d = {sl_q[55:0], byte_i};
          else if (off_q >= 7'd24 && off_q < 7'd32) dh_d = {dh_q[55:0], byte_i};
          else if (off_q >= 7'd32 && off_q < 7'd40) dl_d = {dl_q[55:0], byte_i};
          off_d = off_inc;
          if (off_inc == 7'd40) begin
            hdr_vld               = 1'b1;
            hdr_rec.layer         = LYR_IPV6;
            hdr_rec.status        = ST_OK;
            hdr_rec.src_high      = sh_d;
            hdr_rec.src_low       = sl_d;
            hdr_rec.dst_high      = dh_d;
            hdr_rec.dst_low       = dl_d;
            hdr_rec.type_or_proto = type_d;
            phase_d = ip_next(type_d);
          end
        end
        PH_TCP, PH_UDP: begin
          if (off_q < 7'd2) sl_d = {48'd0, sl_q[7:0], byte_i};
          else if (off_q < 7'd4) dl_d = {48'd0, dl_q[7:0], byte_i};
          off_d = off_inc;
          if (off_inc == ((phase_q == PH_TCP) ? 7'd20 : 7'd8)) begin
            hdr_vld         = 1'b1;
            hdr_rec.layer   = (phase_q == PH_TCP) ? LYR_TCP : LYR_UDP;
            hdr_rec.status  = ST_OK;
            hdr_rec.src_low = sl_d;
            hdr_rec.dst_low = dl_d;
            phase_d = PH_SKIP;
          end
        end
        default: begin
        end
      endcase
      // Entering a new phase clears offset and captured fields
      if (hdr_vld) begin
        off_d  = '0;
        sh_d   = '0;
        sl_d   = '0;
        dh_d   = '0;
        dl_d   = '0;
        type_d = '0;
      end
    end

    if (eof_i) begin
      eof_rec.status = ST_OK;
      case (phase_d)
        PH_ETH: begin
          eof_vld = 1'b1;
          eof_rec.layer = LYR_SHORT;
        end
        PH_IPV4: begin
          eof_vld = 1'b1;
          eof_rec.layer  = LYR_IPV4;
          eof_rec.status = (off_d >= 7'd20) ? ST_TRUNC_IHL : ST_TRUNC;
        end
        PH_IPV6: begin
          eof_vld = 1'b1;
          eof_rec.layer  = LYR_IPV6;
          eof_rec.status = ST_TRUNC;
        end
        PH_TCP: begin
          eof_vld = 1'b1;
          eof_rec.layer  = LYR_TCP;
          eof_rec.status = ST_TRUNC;
        end
        PH_UDP: begin
          eof_vld = 1'b1;
          eof_rec.layer  = LYR_UDP;
          eof_rec.status = ST_TRUNC;
        end
        default: begin
          eof_vld = !hdr_vld;
          eof_rec.layer = LYR_END;
        end
      endcase
      eof_rec.last_of_frame = 1'b1;
      hdr_rec.last_of_frame = !eof_vld;
      phase_d = PH_ETH;
      off_d   = '0;
      ihl_d   = '0;
      cnt_d   = '0;
      sh_d    = '0;
      sl_d    = '0;
      dh_d    = '0;
      dl_d    = '0;
      type_d  = '0;
    end
  end

  // Compact the byte's records so the first slot is always filled first
  always_comb begin
    push_o.first_vld  = accept_i && (hdr_vld || eof_vld);
    push_o.second_vld = accept_i && hdr_vld && eof_vld;
    push_o.first      = hdr_vld ? hdr_rec : eof_rec;
    push_o.second     = eof_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ETH;
      off_q   <= '0;
      ihl_q   <= '0;
      cnt_q   <= '0;
      sh_q    <= '0;
      sl_q    <= '0;
      dh_q    <= '0;
      dl_q    <= '0;
      type_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      ihl_q   <= ihl_d;
      cnt_q   <= cnt_d;
      sh_q    <= sh_d;
      sl_q    <= sl_d;
      dh_q    <= dh_d;
      dl_q    <= dl_d;
      type_q  <= type_d;
    end
  end

endmodule : phdr_parser
`default_nettype wire

### hdl/phdr_rec_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phdr_rec_fifo
// Small record queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module phdr_rec_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire phdr_pkg::push_t push_i,
  output logic              room_o,
  output logic              vld_o,
  input  wire logic         rdy_i,
  output phdr_pkg::rec_t    rec_o
);
  import phdr_pkg::*;

  rec_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_AW:0]     cnt_q, cnt_d;
  logic                 pop;
  logic [FIFO_AW:0]     n_push;

  assign room_o = cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign vld_o  = cnt_q != '0;
  assign rec_o  = mem_q[rd_q];
  assign pop    = vld_o && rdy_i;

  always_comb begin
    n_push = (FIFO_AW+1)'(push_i.first_vld) + (FIFO_AW+1)'(push_i.second_vld);
    wr_d   = wr_q + n_push[FIFO_AW-1:0];
    rd_d   = rd_q + FIFO_AW'(pop);
    cnt_d  = cnt_q + n_push - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) mem_q[wr_q] <= push_i.first;
    if (push_i.second_vld) mem_q[wr_q + FIFO_AW'(1)] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule : phdr_rec_fifo
`default_nettype wire

### hdl/packet_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packet_header_parser
// Ethernet / IPv4 / IPv6 / TCP / UDP header parser, one frame byte a request.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one frame byte per request in tdata, with tlast on
//   the final byte of the frame. The master side gives one record per request:
//   addresses, ports and type in tdata, layer and status in tuser, and tlast
//   on the closing record of each frame.
//   Throughput is one byte per cycle. A byte that completes a header, or ends
//   the frame, pushes one or two records into a four-entry record queue that
//   drains one record per cycle; s_axis_tready drops only while fewer than
//   two queue entries are free, which the sparse records of a frame never
//   reach unless the receiver stalls.
//   Each record enters the queue as its byte is taken and reaches the master
//   side once older records drain; the walker decodes each byte combinationally.
//   Reset clears the walker to expect an Ethernet header and empties the
//   queue. A stalled receiver holds the head record; further bytes are taken
//   until the queue is nearly full, then held off.
// ----------------------------------------------------------------------------
module packet_header_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [7:0]     s_axis_tdata,   // data_byte
  input  wire logic           s_axis_tlast,   // end_of_frame
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [271:0]        m_axis_tdata,   // src_high, src_low, dst_high,
                                              // dst_low, type_or_proto
  output logic [4:0]          m_axis_tuser,   // layer, status
  output logic                m_axis_tlast    // last_of_frame
);
  import phdr_pkg::*;

  logic  accept;
  push_t push;
  rec_t  head;

  // Accept a byte only when the queue can absorb its worst case of two records
  assign accept = s_axis_tvalid && s_axis_tready;

  phdr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .eof_i    (s_axis_tlast),
    .push_o   (push)
  );

  phdr_rec_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (s_axis_tready),
    .vld_o  (m_axis_tvalid),
    .rdy_i  (m_axis_tready),
    .rec_o  (head)
  );

  // Pack the head record onto the master side, first field lowest
  assign m_axis_tdata = {head.type_or_proto, head.dst_low, head.dst_high,
                         head.src_low, head.src_high};
  assign m_axis_tuser = {head.status, head.layer};
  assign m_axis_tlast = head.last_of_frame;

endmodule : packet_header_parser
`default_nettype wire

### dv/packet_header_parser_tb.sv
// ----------------------------------------------------------------------------
// packet_header_parser_tb
// Self-checking bench for the Ethernet / IP / TCP / UDP header parser.
// ----------------------------------------------------------------------------
// Frames are built as byte lists and queued up front, then fed one byte per
// request with random gaps. A behavioural walker in the bench follows each
// accepted byte and queues the records it should cause; every record taken
// from the master side is compared field by field with the oldest one queued.
// The receiver stalls at random, holds off once for a long stretch so that
// the record queue fills and the slave side backs up, and both sides run
// without gaps for a stretch in the middle.
// ----------------------------------------------------------------------------
module packet_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phdr_pkg::*;

  // Run shape
  localparam int RANDOM_BYTES = 1300;
  localparam int HOLD_AT      = 400;    // bytes taken before the long hold-off
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_FROM   = 800;    // no idling on either side in this band
  localparam int QUIET_TO     = 1200;
  // About 2000 bytes at worst two records each, with random gaps and the long
  // hold-off: this limit is many times the slowest correct run.
  localparam int CYCLE_LIMIT  = 100000;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } frame_byte_t;

  logic         clk   = 1'b0;
  logic         rst_n = 1'b0;

  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [7:0]   s_data  = 8'h00;
  logic         s_last  = 1'b0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [271:0] m_data;
  logic [4:0]   m_user;
  logic         m_last;

  frame_byte_t  bytes_to_send[$];
  rec_t         records_due[$];

  int           bytes_taken  = 0;
  int           records_seen = 0;
  int           mismatches   = 0;
  int           cycle_count  = 0;
  int           hold_left    = 0;
  bit           hold_done    = 1'b0;
  bit           byte_taken   = 1'b0;
  logic         idling_on;

  // Header walker state, kept apart from the block
  logic [2:0]   walk_phase;
  int unsigned  walk_off;
  logic [5:0]   ip_hdr_len;
  logic [15:0]  frame_bytes;
  logic [63:0]  cap_src_hi, cap_src_lo, cap_dst_hi, cap_dst_lo;
  logic [15:0]  cap_type;
  rec_t         byte_recs[2];
  int           byte_nrecs;

  always #1 clk = ~clk;

  assign idling_on = !(bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO);

  packet_header_parser u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  // --------------------------------------------------------------------------
  // Header walker
  // --------------------------------------------------------------------------

  // Start a new header: drop whatever was captured for the last one
  task automatic enter_walk(input logic [2:0] ph);
    walk_phase = ph;
    walk_off   = 0;
    cap_src_hi = '0;
    cap_src_lo = '0;
    cap_dst_hi = '0;
    cap_dst_lo = '0;
    cap_type   = '0;
  endtask

  task automatic emit(input logic [2:0] layer, input logic [1:0] status,
                      input logic [63:0] sh, input logic [63:0] sl,
                      input logic [63:0] dh, input logic [63:0] dl,
                      input logic [15:0] t);
    byte_recs[byte_nrecs] = '{layer, status, sh, sl, dh, dl, t, 1'b0};
    byte_nrecs++;
  endtask

  function automatic logic [2:0] after_ip(input logic [15:0] proto);
    if (proto == 16'(PROTO_TCP)) return PH_TCP;
    if (proto == 16'(PROTO_UDP)) return PH_UDP;
    return PH_SKIP;
  endfunction

  task automatic walk_byte(input logic [7:0] b);
    int unsigned off;
    off      = walk_off;
    walk_off = off + 1;
    case (walk_phase)
      PH_ETH: begin
        if (off < 6) cap_dst_lo = {cap_dst_lo[55:0], b};
        else if (off < 12) cap_src_lo = {cap_src_lo[55:0], b};
        else cap_type = {cap_type[7:0], b};
        if (walk_off == 14) begin
          emit(LYR_ETH, ST_OK, '0, cap_src_lo, '0, cap_dst_lo, cap_type);
          if (cap_type == ETYPE_IPV4) enter_walk(PH_IPV4);
          else if (cap_type == ETYPE_IPV6) enter_walk(PH_IPV6);
          else enter_walk(PH_SKIP);
        end
      end
      PH_IPV4: begin
        if (off == 0) ip_hdr_len = 6'(b[3:0] * IHL_UNIT);
        else if (off == 9) cap_type = {8'h00, b};
        else if (off >= 12 && off < 16) cap_src_lo = {cap_src_lo[55:0], b};
        else if (off >= 16 && off < 20) cap_dst_lo = {cap_dst_lo[55:0], b};
        // A header length below five words is reported once the fixed part is in
        if (walk_off == 20 && ip_hdr_len < 20) begin
          emit(LYR_IPV4, ST_BAD_IHL, '0, cap_src_lo, '0, cap_dst_lo, cap_type);
          enter_walk(PH_SKIP);
        end else if (walk_off >= 20 && walk_off >= ip_hdr_len) begin
          emit(LYR_IPV4, ST_OK, '0, cap_src_lo, '0, cap_dst_lo, cap_type);
          enter_walk(after_ip(cap_type));
        end
      end
      PH_IPV6: begin
        if (off == 6) cap_type = {8'h00, b};
        else if (off >= 8 && off < 16) cap_src_hi = {cap_src_hi[55:0], b};
        else if (off >= 16 && off < 24) cap_src_lo = {cap_src_lo[55:0], b};
        else if (off >= 24 && off < 32) cap_dst_hi = {cap_dst_hi[55:0], b};
        else if (off >= 32 && off < 40) cap_dst_lo = {cap_dst_lo[55:0], b};
        if (walk_off == 40) begin
          emit(LYR_IPV6, ST_OK, cap_src_hi, cap_src_lo, cap_dst_hi, cap_dst_lo,
               cap_type);
          enter_walk(after_ip(cap_type));
        end
      end
      PH_TCP, PH_UDP: begin
        if (off < 2) cap_src_lo = {48'h0, cap_src_lo[7:0], b};
        else if (off < 4) cap_dst_lo = {48'h0, cap_dst_lo[7:0], b};
        if (walk_off == ((walk_phase == PH_TCP) ? 20 : 8)) begin
          emit((walk_phase == PH_TCP) ? LYR_TCP : LYR_UDP, ST_OK,
               '0, cap_src_lo, '0, cap_dst_lo, '0);
          enter_walk(PH_SKIP);
        end
      end
      default: ;
    endcase
  endtask

  // Advance the walker by one accepted byte and queue the records it causes
  task automatic predict_byte(input logic [7:0] b, input logic eof);
    byte_nrecs = 0;
    // Bytes past the length limit are counted out, not parsed
    if (frame_bytes < MAX_FRAME_BYTES) begin
      frame_bytes++;
      walk_byte(b);
    end
    if (eof) begin
      case (walk_phase)
        PH_ETH:  emit(LYR_SHORT, ST_OK, '0, '0, '0, '0, '0);
        PH_IPV4: emit(LYR_IPV4, (walk_off >= 20) ? ST_TRUNC_IHL : ST_TRUNC,
                      '0, '0, '0, '0, '0);
        PH_IPV6: emit(LYR_IPV6, ST_TRUNC, '0, '0, '0, '0, '0);
        PH_TCP:  emit(LYR_TCP, ST_TRUNC, '0, '0, '0, '0, '0);
        PH_UDP:  emit(LYR_UDP, ST_TRUNC, '0, '0, '0, '0, '0);
        default: if (byte_nrecs == 0) emit(LYR_END, ST_OK, '0, '0, '0, '0, '0);
      endcase
      byte_recs[byte_nrecs - 1].last_of_frame = 1'b1;
      enter_walk(PH_ETH);
      ip_hdr_len  = '0;
      frame_bytes = '0;
    end
    for (int i = 0; i < byte_nrecs; i++) records_due = {records_due, byte_recs[i]};
  endtask

  // --------------------------------------------------------------------------
  // Frame building
  // --------------------------------------------------------------------------

  // A negative fill gives random bytes, otherwise the fill value itself
  function automatic logic [7:0] pad_byte(input int fill);
    return (fill < 0) ? 8'($urandom) : 8'(fill);
  endfunction

  // Build one frame and queue its bytes. A cut shorter than the frame ends it
  // early, anywhere, so truncation falls inside any header.
  task automatic add_frame(input logic [15:0] etype, input logic [7:0] ip_first,
                           input logic [7:0] proto, input int payload,
                           input int cut, input int fill, inout int counted);
    logic [7:0]  fb[$];
    int          hdr_len;
    bit          to_l4;
    frame_byte_t fbyte;
    to_l4 = 1'b0;
    repeat (12) fb = {fb, pad_byte(fill)};
    fb = {fb, etype[15:8]};
    fb = {fb, etype[7:0]};
    if (etype == ETYPE_IPV4) begin
      // A short header length still puts the fixed 20 bytes on the wire
      hdr_len = (ip_first[3:0] < 5) ? 20 : ip_first[3:0] * IHL_UNIT;
      fb = {fb, ip_first};
      for (int i = 1; i < hdr_len; i++) fb = {fb, (i == 9) ? proto : pad_byte(fill)};
      to_l4 = (ip_first[3:0] >= 5);
    end else if (etype == ETYPE_IPV6) begin
      for (int i = 0; i < 40; i++) fb = {fb, (i == 6) ? proto : pad_byte(fill)};
      to_l4 = 1'b1;
    end
    if (to_l4 && proto == PROTO_TCP) repeat (20) fb = {fb, pad_byte(fill)};
    else if (to_l4 && proto == PROTO_UDP) repeat (8) fb = {fb, pad_byte(fill)};
    repeat (payload) fb = {fb, pad_byte(fill)};
    if (cut > 0) while (fb.size() > cut) fb.delete(fb.size() - 1);
    foreach (fb[i]) begin
      fbyte.data = fb[i];
      fbyte.eof  = (i == fb.size() - 1);
      bytes_to_send = {bytes_to_send, fbyte};
    end
    counted += fb.size();
  endtask

  // Mostly well-formed IPv4 / IPv6 frames with TCP or UDP, some cut short,
  // some with odd header lengths, protocols or EtherTypes
  task automatic add_random_frame(inout int counted);
    logic [15:0] etype;
    logic [7:0]  first;
    logic [7:0]  proto;
    int          pick;
    int          cut;
    pick  = $urandom_range(99);
    etype = (pick < 45) ? ETYPE_IPV4 : (pick < 80) ? ETYPE_IPV6 : 16'($urandom);
    first = 8'($urandom);
    pick  = $urandom_range(9);
    if (pick >= 1 && pick <= 5) first[3:0] = 4'd5;
    else if (pick > 5) first[3:0] = 4'($urandom_range(15, 6));
    pick  = $urandom_range(99);
    proto = (pick < 45) ? PROTO_TCP : (pick < 80) ? PROTO_UDP : 8'($urandom);
    cut   = ($urandom_range(3) == 0) ? $urandom_range(100, 1) : 0;
    add_frame(etype, first, proto, $urandom_range(6), cut, -1, counted);
  endtask

  // --------------------------------------------------------------------------
  // Report
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    mismatches++;
    if (mismatches <= 50)
      $display("[%0t] record %0d %s: got %0h, want %0h", $time, records_seen, what,
               got_v, want_v);
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: offer the next byte at the falling edge once the last one
  // has gone, or idle now and then
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    frame_byte_t nb;
    if (rst_n && (!s_valid || byte_taken)) begin
      if (bytes_to_send.size() != 0 && !(idling_on && $urandom_range(99) < 17)) begin
        nb = bytes_to_send.pop_front();
        s_valid <= 1'b1;
        s_data  <= nb.data;
        s_last  <= nb.eof;
      end else begin
        s_valid <= 1'b0;
        s_data  <= 8'($urandom);
        s_last  <= 1'($urandom);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Record receiver: random stalls, plus one long hold-off so the record
  // queue fills and the slave side is held off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= !(idling_on && $urandom_range(99) < 17);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check records taken at this edge, then predict from the byte
  // taken at this edge (its records can only show up later)
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rec_t got;
    rec_t want;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        // tdata: src_high, src_low, dst_high, dst_low, type_or_proto from bit 0
        got = '{m_user[2:0], m_user[4:3], m_data[63:0], m_data[127:64],
                m_data[191:128], m_data[255:192], m_data[271:256], m_last};
        if (records_due.size() == 0) begin
          report_mismatch("record with none due, layer", 64'(got.layer), '0);
        end else begin
          want = records_due.pop_front();
          if (got.layer != want.layer)
            report_mismatch("layer", 64'(got.layer), 64'(want.layer));
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.src_high != want.src_high)
            report_mismatch("src_high", got.src_high, want.src_high);
          if (got.src_low != want.src_low)
            report_mismatch("src_low", got.src_low, want.src_low);
          if (got.dst_high != want.dst_high)
            report_mismatch("dst_high", got.dst_high, want.dst_high);
          if (got.dst_low != want.dst_low)
            report_mismatch("dst_low", got.dst_low, want.dst_low);
          if (got.type_or_proto != want.type_or_proto)
            report_mismatch("type_or_proto", 64'(got.type_or_proto),
                            64'(want.type_or_proto));
          if (got.last_of_frame != want.last_of_frame)
            report_mismatch("last_of_frame", 64'(got.last_of_frame),
                            64'(want.last_of_frame));
        end
        records_seen++;
      end
      byte_taken = s_valid && s_ready;
      if (byte_taken) begin
        predict_byte(s_data, s_last);
        bytes_taken++;
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int directed_bytes;
    int random_bytes;
    int drain;
    directed_bytes = 0;
    random_bytes   = 0;
    enter_walk(PH_ETH);
    ip_hdr_len  = '0;
    frame_bytes = '0;

    // Frame ends inside the Ethernet header: one byte, then 13 bytes of ones
    add_frame(16'h0000, 8'h00, 8'h00, 0, 1, 8'h00, directed_bytes);
    add_frame(16'hFFFF, 8'h00, 8'h00, 0, 13, 8'hFF, directed_bytes);
    // Unknown EtherType, header completes on the final byte
    add_frame(16'hFFFF, 8'h00, 8'h00, 0, 0, 8'hFF, directed_bytes);
    // IPv4 EtherType, frame ends before any IPv4 byte
    add_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, 0, 14, -1, directed_bytes);
    // Plain IPv4 / TCP with payload, zero addresses
    add_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, 4, 0, 8'h00, directed_bytes);
    // Maximum header length cut inside the options
    add_frame(ETYPE_IPV4, 8'h4F, PROTO_UDP, 0, 44, -1, directed_bytes);
    // Header length below five words, and zero, the latter ending on its record
    add_frame(ETYPE_IPV4, 8'h42, PROTO_TCP, 3, 0, -1, directed_bytes);
    add_frame(ETYPE_IPV4, 8'hF0, PROTO_TCP, 0, 34, 8'hFF, directed_bytes);
    // Options skipped before UDP
    add_frame(ETYPE_IPV4, 8'h46, PROTO_UDP, 2, 0, 8'hFF, directed_bytes);
    // IPv6 completes on the final byte, TCP then truncated at once
    add_frame(ETYPE_IPV6, 8'h00, PROTO_TCP, 0, 54, 8'hFF, directed_bytes);
    // IPv6 / UDP ending exactly on the UDP header
    add_frame(ETYPE_IPV6, 8'h00, PROTO_UDP, 0, 0, 8'h00, directed_bytes);
    // IPv6 with an unknown next header, then payload
    add_frame(ETYPE_IPV6, 8'h00, 8'hFF, 5, 0, -1, directed_bytes);
    // IPv6 truncated mid-header
    add_frame(ETYPE_IPV6, 8'h00, PROTO_TCP, 0, 30, -1, directed_bytes);
    // IPv4 with another protocol, ending on the IPv4 header
    add_frame(ETYPE_IPV4, 8'h45, 8'd1, 0, 0, -1, directed_bytes);
    // UDP truncated
    add_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, 0, 39, -1, directed_bytes);
    // Longest IPv4 header, all ones, then TCP
    add_frame(ETYPE_IPV4, 8'h4F, PROTO_TCP, 0, 0, 8'hFF, directed_bytes);

    while (random_bytes < RANDOM_BYTES) add_random_frame(random_bytes);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to be taken; sample at the rising edge, where the
    // driver's signals are settled
    do @(posedge clk); while (bytes_to_send.size() != 0 || s_valid);

    // Then let the records drain, and keep waiting after that for any stray ones
    drain = 0;
    while (records_due.size() != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (10) @(negedge clk);
    if (records_due.size() != 0)
      report_mismatch("records never produced, count", 64'(records_due.size()), '0);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
